### rtl/mlfq_pkg.sv
package mlfq_pkg;

  typedef enum logic [2:0] {
    ST_LOADED   = 3'd0,
    ST_DISPATCH = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADLEVEL = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [4:0] QUANTUM_DEFAULT = 5'd10;
  localparam logic [15:0] THRESH_DEFAULT = 16'd100;

  localparam logic CFG_QUANTUM = 1'b0;
  localparam logic CFG_THRESH  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_PICK,
    S_RUN,
    S_AGE_SCAN,
    S_AGE_DO,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       clr_scan;
    logic       scan_step;
    logic       load_wr;
    logic       run;
    logic       age_do;
    logic [1:0] age_level;
    logic       age_mode;
    logic       emit;
    status_t    emit_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic have_free;
    logic full;
    logic found_any;
    logic age_hit;
  } sts_t;

endpackage

### rtl/mlfq_ctrl.sv
module mlfq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_opcode,
  input  logic [2:0]    in_start_level,
  output logic          busy,
  output mlfq_pkg::cmd_t cmd,
  input  mlfq_pkg::sts_t sts
);
  import mlfq_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] lvl_r, lvl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lvl_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    cmd       = '0;
    cmd.emit_status = ST_LOADED;
    cmd.age_level   = lvl_r;
    busy      = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_opcode == OP_LOAD && (in_start_level < 3'd1 || in_start_level > 3'd4)) begin
            cmd.emit = 1'b1;
            cmd.emit_status = ST_BADLEVEL;
          end else begin
            cmd.clr_scan = 1'b1;
            cmd.age_mode = 1'b0;
            state_nxt = (in_opcode == OP_LOAD) ? S_LOAD : S_SCAN;
          end
        end
      end
      S_LOAD: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_PICK;
      end
      S_PICK: begin
        if (sts.full || !sts.have_free) begin
          cmd.emit = 1'b1;
          cmd.emit_status = ST_FULL;
        end else begin
          cmd.load_wr = 1'b1;
          cmd.emit = 1'b1;
          cmd.emit_status = ST_LOADED;
        end
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_RUN;
      end
      S_RUN: begin
        if (!sts.found_any) begin
          cmd.emit = 1'b1;
          cmd.emit_status = ST_EMPTY;
          state_nxt = S_IDLE;
        end else begin
          cmd.run = 1'b1;
          cmd.clr_scan = 1'b1;
          lvl_nxt = 2'd1;          // level 2 encoded as index 1
          state_nxt = S_AGE_SCAN;
        end
      end
      S_AGE_SCAN: begin
        cmd.age_mode = 1'b1;
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_AGE_DO;
      end
      S_AGE_DO: begin
        cmd.age_mode = 1'b1;
        cmd.age_do = sts.age_hit;
        cmd.clr_scan = 1'b1;
        if (lvl_r == 2'd3) state_nxt = S_DONE;
        else begin
          lvl_nxt = lvl_r + 2'd1;
          state_nxt = S_AGE_SCAN;
        end
      end
      S_DONE: begin
        cmd.emit = 1'b1;
        cmd.emit_status = ST_DISPATCH;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

### rtl/mlfq_dp.sv
module mlfq_dp #(
  parameter int MAX_PROCS  = 64,
  parameter int CLOCK_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_data,
  input  logic           start,
  input  logic           busy,
  input  logic [15:0]    in_proc_id,
  input  logic [2:0]     in_start_level,
  input  logic [15:0]    in_burst_ms,
  input  mlfq_pkg::cmd_t cmd,
  output mlfq_pkg::sts_t sts,
  output logic           out_strobe,
  output logic [2:0]     out_status,
  output logic [15:0]    out_run_id,
  output logic [15:0]    out_ran_ms,
  output logic           out_finished,
  output logic [2:0]     out_origin_level,
  output logic [2:0]     out_final_level,
  output logic [31:0]    out_completion_ms,
  output logic [6:0]     out_waiting_count
);
  import mlfq_pkg::*;

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int RW = 16 + 2 + 2 + 16 + CLOCK_BITS + 32;

  // slot word in the memory; levels kept as 2-bit code (level-1)
  typedef struct packed {
    logic [15:0]           id;
    logic [1:0]            olev;
    logic [1:0]            lev;
    logic [15:0]           rem;
    logic [CLOCK_BITS-1:0] since;
    logic [31:0]           ord;
  } slot_t;

  logic valid_r [MAX_PROCS];

  logic [4:0]  quantum_r;
  logic [15:0] thresh_r;
  logic [CLOCK_BITS-1:0] clock_r;
  logic [31:0] order_r;
  logic [CW-1:0] held_r;

  logic [15:0] ld_id_r, ld_burst_r;
  logic [1:0]  ld_lev_r;

  // scan state: address stage and compare stage
  logic [IW:0]   idx_r;
  logic          p_vld_r;
  logic [IW-1:0] p_idx_r;
  logic          bfound_r;
  logic [IW-1:0] bsel_r;
  slot_t         best_r;
  logic [31:0]   bage_r;
  logic          ffree_r;
  logic [IW-1:0] fsel_r;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  slot_t         ram_wdata;
  logic [RW-1:0] ram_rdata;
  slot_t         rd;

  logic [IW-1:0] idx;
  logic          idx_done;
  logic [31:0]   age_c;
  logic          better;
  logic          match;
  assign idx      = idx_r[IW-1:0];
  assign idx_done = (idx_r == (IW+1)'(MAX_PROCS));
  assign rd       = slot_t'(ram_rdata);
  assign age_c    = order_r - rd.ord;

  mlfq_ram #(.WIDTH(RW), .DEPTH(MAX_PROCS)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata), .raddr(idx),
    .rdata_r(ram_rdata)
  );

  always_comb begin
    match  = p_vld_r && valid_r[p_idx_r] && (!cmd.age_mode || rd.lev == cmd.age_level);
    better = 1'b0;
    if (match) begin
      if (!bfound_r) better = 1'b1;
      else if (rd.lev < best_r.lev) better = 1'b1;
      else if (rd.lev == best_r.lev) begin
        if (rd.lev == 2'd1 || rd.lev == 2'd2)
          better = (rd.rem < best_r.rem) || (rd.rem == best_r.rem && age_c > bage_r);
        else
          better = age_c > bage_r;
      end
    end
  end

  logic [CLOCK_BITS-1:0] wait_c;
  assign wait_c = clock_r - best_r.since;

  assign sts.scan_last = p_vld_r && (p_idx_r == IW'(MAX_PROCS - 1));
  assign sts.have_free = ffree_r;
  assign sts.full      = (held_r == CW'(MAX_PROCS));
  assign sts.found_any = bfound_r;
  assign sts.age_hit   = bfound_r && (wait_c > CLOCK_BITS'(thresh_r));

  // run results
  logic [15:0] run_amt;
  logic        req;
  assign req     = (best_r.lev == 2'd0) && (16'(quantum_r) < best_r.rem);
  assign run_amt = req ? 16'(quantum_r) : best_r.rem;

  // slot write: new load, round robin requeue or promotion
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bsel_r;
    ram_wdata = best_r;
    if (cmd.load_wr) begin
      ram_we          = 1'b1;
      ram_waddr       = fsel_r;
      ram_wdata.id    = ld_id_r;
      ram_wdata.olev  = ld_lev_r;
      ram_wdata.lev   = ld_lev_r;
      ram_wdata.rem   = ld_burst_r;
      ram_wdata.since = clock_r;
      ram_wdata.ord   = order_r;
    end else if (cmd.run) begin
      ram_we          = req;
      ram_wdata.rem   = best_r.rem - run_amt;
      ram_wdata.since = clock_r + CLOCK_BITS'(run_amt);
      ram_wdata.ord   = order_r;
    end else if (cmd.age_do) begin
      ram_we          = 1'b1;
      ram_wdata.lev   = best_r.lev - 2'd1;
      ram_wdata.since = clock_r;
      ram_wdata.ord   = order_r;
    end
  end

  logic [15:0] r_id_r, r_ran_r;
  logic        r_fin_r;
  logic [2:0]  r_olev_r, r_flev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_DEFAULT;
      thresh_r  <= THRESH_DEFAULT;
      clock_r   <= '0;
      order_r   <= '0;
      held_r    <= '0;
      out_strobe <= 1'b0;
      for (int i = 0; i < MAX_PROCS; i++) valid_r[i] <= 1'b0;
    end else begin
      out_strobe <= cmd.emit;
      if (cfg_we) begin
        if (cfg_index == CFG_QUANTUM) quantum_r <= cfg_data[4:0];
        else thresh_r <= cfg_data;
      end
      if (cmd.load_wr) begin
        valid_r[fsel_r] <= 1'b1;
        held_r <= held_r + CW'(1);
        order_r <= order_r + 32'd1;
      end
      if (cmd.run) begin
        clock_r <= clock_r + CLOCK_BITS'(run_amt);
        if (req) order_r <= order_r + 32'd1;
        else begin
          valid_r[bsel_r] <= 1'b0;
          held_r <= held_r - CW'(1);
        end
      end
      if (cmd.age_do) order_r <= order_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      ld_id_r    <= in_proc_id;
      ld_burst_r <= in_burst_ms;
      ld_lev_r   <= 2'(in_start_level - 3'd1);
    end
    if (cmd.clr_scan) begin
      idx_r <= '0; p_vld_r <= 1'b0; bfound_r <= 1'b0; ffree_r <= 1'b0;
    end else if (cmd.scan_step) begin
      // read address runs one slot ahead of the compare
      if (!idx_done) begin
        idx_r   <= idx_r + (IW+1)'(1);
        p_idx_r <= idx;
      end
      p_vld_r <= !idx_done;
      if (better) begin
        bfound_r <= 1'b1; bsel_r <= p_idx_r; best_r <= rd; bage_r <= age_c;
      end
      if (p_vld_r && !valid_r[p_idx_r] && !ffree_r) begin
        ffree_r <= 1'b1; fsel_r <= p_idx_r;
      end
    end
    if (cmd.run) begin
      r_id_r   <= best_r.id;
      r_ran_r  <= run_amt;
      r_fin_r  <= !req;
      r_olev_r <= 3'(best_r.olev) + 3'd1;
      r_flev_r <= 3'(best_r.lev) + 3'd1;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status        <= cmd.emit_status;
      out_waiting_count <= 7'(held_r + ((cmd.emit_status == ST_LOADED) ? CW'(1) : CW'(0)));
      if (cmd.emit_status == ST_DISPATCH) begin
        out_run_id        <= r_id_r;
        out_ran_ms        <= r_ran_r;
        out_finished      <= r_fin_r;
        out_origin_level  <= r_olev_r;
        out_final_level   <= r_flev_r;
        out_completion_ms <= 32'(clock_r);
      end else begin
        out_run_id <= '0; out_ran_ms <= '0; out_finished <= 1'b0;
        out_origin_level <= '0; out_final_level <= '0; out_completion_ms <= '0;
      end
    end
  end
endmodule

// generic memory, one write port and one registered read port
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end
endmodule

### rtl/multilevel_feedback_queue_scheduler_unit.sv
// throughput: one word at a time; each table scan reads one slot a cycle from the
// slot memory, compare in the cycle after the read
// busy is high while an item is in work; out_strobe marks each result word
// synchronous active-low reset empties the table and zeroes clock and counters
// the receiver cannot stall; no clearing pass after reset
module multilevel_feedback_queue_scheduler_unit #(
  parameter int MAX_PROCS  = 64,
  parameter int CLOCK_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [15:0] in_proc_id,
  input  logic [2:0]  in_start_level,
  input  logic [15:0] in_burst_ms,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [15:0] out_run_id,
  output logic [15:0] out_ran_ms,
  output logic        out_finished,
  output logic [2:0]  out_origin_level,
  output logic [2:0]  out_final_level,
  output logic [31:0] out_completion_ms,
  output logic [6:0]  out_waiting_count
);
  import mlfq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: load scan, dispatch scan, three aging scans
  mlfq_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_opcode, .in_start_level, .busy, .cmd, .sts
  );

  // slot table, virtual clock and result word
  mlfq_dp #(.MAX_PROCS(MAX_PROCS), .CLOCK_BITS(CLOCK_BITS)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .start, .busy,
    .in_proc_id, .in_start_level, .in_burst_ms, .cmd, .sts,
    .out_strobe, .out_status, .out_run_id, .out_ran_ms, .out_finished,
    .out_origin_level, .out_final_level, .out_completion_ms, .out_waiting_count
  );
endmodule

### dv/multilevel_feedback_queue_scheduler_unit_test.sv
`timescale 1ns / 100ps

module multilevel_feedback_queue_scheduler_unit_test;
  import mlfq_pkg::*;

  localparam int NSLOT = 64;
  // settle time covers the worst dispatch, with room on top
  localparam int SETTLE = 300;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic        op;
    logic [15:0] pid;
    logic [2:0]  lvl;
    logic [15:0] burst;
  } sched_req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] run_id;
    logic [15:0] ran_ms;
    logic        finished;
    logic [2:0]  origin_level;
    logic [2:0]  final_level;
    logic [31:0] completion_ms;
    logic [6:0]  waiting_count;
  } sched_res_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        start;
  logic        busy;
  logic        in_opcode;
  logic [15:0] in_proc_id;
  logic [2:0]  in_start_level;
  logic [15:0] in_burst_ms;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic [15:0] out_run_id;
  logic [15:0] out_ran_ms;
  logic        out_finished;
  logic [2:0]  out_origin_level;
  logic [2:0]  out_final_level;
  logic [31:0] out_completion_ms;
  logic [6:0]  out_waiting_count;

  multilevel_feedback_queue_scheduler_unit dut (.*);

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // shadow scheduler state
  logic        slot_used  [NSLOT];
  logic [15:0] slot_pid   [NSLOT];
  logic [2:0]  slot_origin[NSLOT];
  logic [2:0]  slot_level [NSLOT];
  logic [15:0] slot_left  [NSLOT];
  logic [31:0] slot_since [NSLOT];
  logic [31:0] slot_seq   [NSLOT];
  logic [31:0] virt_clock;
  logic [31:0] seq_ctr;
  int          held_procs;
  logic [4:0]  slice_ms;
  logic [15:0] promote_ms;

  sched_req_t  word_q[$];
  sched_res_t  sched_exp_q[$];
  sched_req_t  cur_word;
  bit          took;
  bit          no_idle;
  int          gap;
  int          mismatches;
  int          stall_cycles;

  // head of a level: fifo order for 1 and 4, shortest remaining then oldest for 2 and 3
  function automatic int level_head(int lvl);
    int best;
    best = -1;
    for (int s = 0; s < NSLOT; s++) begin
      if (!slot_used[s] || slot_level[s] != lvl) continue;
      if (best < 0) best = s;
      else if (lvl == 2 || lvl == 3) begin
        if (slot_left[s] < slot_left[best] ||
            (slot_left[s] == slot_left[best] &&
             (seq_ctr - slot_seq[s]) > (seq_ctr - slot_seq[best])))
          best = s;
      end else if ((seq_ctr - slot_seq[s]) > (seq_ctr - slot_seq[best])) begin
        best = s;
      end
    end
    return best;
  endfunction

  task automatic enqueue_slot(int s, int lvl);
    slot_level[s] = lvl[2:0];
    slot_since[s] = virt_clock;
    slot_seq[s]   = seq_ctr;
    seq_ctr       = seq_ctr + 1;
  endtask

  task automatic promote_if_stale(int lvl);
    int h;
    h = level_head(lvl);
    if (h >= 0 && (virt_clock - slot_since[h]) > {16'd0, promote_ms})
      enqueue_slot(h, lvl - 1);
  endtask

  task automatic schedule_word(sched_req_t w, output sched_res_t r);
    int s;
    int h;
    logic [15:0] run;
    r = '{status: ST_LOADED, default: '0};
    if (w.op == OP_LOAD) begin
      s = 0;
      while (s < NSLOT && slot_used[s]) s++;
      if (w.lvl < 1 || w.lvl > 4) r.status = ST_BADLEVEL;
      else if (s >= NSLOT) r.status = ST_FULL;
      else begin
        slot_used[s]   = 1'b1;
        slot_pid[s]    = w.pid;
        slot_origin[s] = w.lvl;
        slot_left[s]   = w.burst;
        enqueue_slot(s, w.lvl);
        held_procs++;
      end
    end else begin
      h = -1;
      for (int l = 1; l <= 4 && h < 0; l++) h = level_head(l);
      if (h < 0) r.status = ST_EMPTY;
      else begin
        r.status       = ST_DISPATCH;
        r.run_id       = slot_pid[h];
        r.origin_level = slot_origin[h];
        r.final_level  = slot_level[h];
        // round robin slice only when the burst outlasts it
        if (slot_level[h] == 1 && {11'd0, slice_ms} < slot_left[h]) begin
          run = {11'd0, slice_ms};
          virt_clock = virt_clock + run;
          slot_left[h] = slot_left[h] - run;
          enqueue_slot(h, 1);
        end else begin
          run = slot_left[h];
          virt_clock = virt_clock + run;
          slot_used[h] = 1'b0;
          held_procs--;
          r.finished = 1'b1;
        end
        r.ran_ms        = run;
        r.completion_ms = virt_clock;
        promote_if_stale(2);
        promote_if_stale(3);
        promote_if_stale(4);
      end
    end
    r.waiting_count = held_procs[6:0];
  endtask

  // result check and prediction on accepted words
  always @(posedge clk) begin
    sched_res_t want;
    sched_res_t got;
    sched_res_t pred;
    if (rst_n) begin
      if (out_strobe || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (out_strobe) begin
        got = '{status: status_t'(out_status), run_id: out_run_id, ran_ms: out_ran_ms,
                finished: out_finished, origin_level: out_origin_level,
                final_level: out_final_level, completion_ms: out_completion_ms,
                waiting_count: out_waiting_count};
        if (sched_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word status %0d", out_status);
        end else begin
          want = sched_exp_q.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp st=%0d id=%h ran=%0d fin=%b org=%0d lvl=%0d clk=%0d n=%0d",
                       want.status, want.run_id, want.ran_ms, want.finished,
                       want.origin_level, want.final_level, want.completion_ms,
                       want.waiting_count);
              $display("          got st=%0d id=%h ran=%0d fin=%b org=%0d lvl=%0d clk=%0d n=%0d",
                       got.status, got.run_id, got.ran_ms, got.finished,
                       got.origin_level, got.final_level, got.completion_ms,
                       got.waiting_count);
            end
          end
        end
      end
      // input word taken at this edge
      if (start && !busy) begin
        schedule_word(cur_word, pred);
        sched_exp_q.push_back(pred);
        took = 1'b1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // driver: one word at a time from word_q, random gap before each
  always @(negedge clk) begin
    if (rst_n) begin
      if (took) begin
        took = 1'b0;
        start <= 1'b0;
        gap = no_idle ? 0 : $urandom_range(0, 11);
      end else if (!start && word_q.size() > 0) begin
        if (gap > 0) gap--;
        else begin
          cur_word = word_q.pop_front();
          in_opcode      <= cur_word.op;
          in_proc_id     <= cur_word.pid;
          in_start_level <= cur_word.lvl;
          in_burst_ms    <= cur_word.burst;
          start          <= 1'b1;
        end
      end
    end
  end

  function automatic sched_req_t mk_word(logic op, logic [15:0] pid, logic [2:0] lvl,
                                        logic [15:0] burst);
    sched_req_t w;
    w.op = op;
    w.pid = pid;
    w.lvl = lvl;
    w.burst = burst;
    return w;
  endfunction

  // mostly well-formed loads and dispatches, a little noise
  function automatic sched_req_t rand_word(int load_pct);
    int r;
    logic [15:0] b;
    r = $urandom_range(0, 99);
    if (r < 5)
      return mk_word(1'($urandom_range(0, 1)), 16'($urandom), 3'($urandom_range(0, 7)),
                     16'($urandom));
    if ($urandom_range(0, 99) < load_pct) begin
      r = $urandom_range(0, 15);
      if (r == 0) b = 16'd0;
      else if (r < 3) b = 16'($urandom);
      else b = 16'($urandom_range(1, 40));
      return mk_word(OP_LOAD, 16'($urandom), 3'($urandom_range(1, 4)), b);
    end
    return mk_word(OP_DISPATCH, 16'($urandom), 3'($urandom_range(0, 7)), 16'($urandom));
  endfunction

  // settle: queue drained, results in, then the dispatch latency
  task automatic wait_idle();
    wait (word_q.size() == 0 && !start && sched_exp_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_QUANTUM) slice_ms = val[4:0];
    else promote_ms = val;
  endtask

  task automatic run_phase(logic [15:0] q, logic [15:0] th, int n, int load_pct,
                           bit quiet);
    wait_idle();
    cfg_write(CFG_QUANTUM, q);
    cfg_write(CFG_THRESH, th);
    no_idle = quiet;
    for (int i = 0; i < n; i++) word_q.push_back(rand_word(load_pct));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_QUANTUM;
    cfg_data = '0;
    start = 1'b0;
    in_opcode = OP_LOAD;
    in_proc_id = '0;
    in_start_level = '0;
    in_burst_ms = '0;
    took = 1'b0;
    no_idle = 1'b0;
    gap = 0;
    mismatches = 0;
    stall_cycles = 0;
    for (int s = 0; s < NSLOT; s++) slot_used[s] = 1'b0;
    virt_clock = '0;
    seq_ctr = '0;
    held_procs = 0;
    slice_ms = QUANTUM_DEFAULT;
    promote_ms = THRESH_DEFAULT;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty dispatch, bad levels, burst extremes, equal-burst tie, drain
    word_q.push_back(mk_word(OP_DISPATCH, 16'h0000, 3'd0, 16'h0000));
    word_q.push_back(mk_word(OP_LOAD, 16'hffff, 3'd0, 16'hffff));
    word_q.push_back(mk_word(OP_LOAD, 16'hffff, 3'd5, 16'd1));
    word_q.push_back(mk_word(OP_LOAD, 16'h0000, 3'd7, 16'd1));
    word_q.push_back(mk_word(OP_LOAD, 16'h0000, 3'd1, 16'd25));
    word_q.push_back(mk_word(OP_LOAD, 16'hffff, 3'd2, 16'd0));
    word_q.push_back(mk_word(OP_LOAD, 16'h1234, 3'd3, 16'hffff));
    word_q.push_back(mk_word(OP_LOAD, 16'h0004, 3'd4, 16'd5));
    word_q.push_back(mk_word(OP_LOAD, 16'h0011, 3'd1, 16'd1));
    word_q.push_back(mk_word(OP_LOAD, 16'h0031, 3'd3, 16'd3));
    word_q.push_back(mk_word(OP_LOAD, 16'h0032, 3'd3, 16'd3));
    for (int i = 0; i < 11; i++)
      word_q.push_back(mk_word(OP_DISPATCH, 16'hffff, 3'd7, 16'hffff));

    // random phases across register settings, extremes included
    run_phase(16'd10, 16'd100, 150, 55, 1'b0);
    run_phase(16'd20, 16'd50000, 130, 85, 1'b0);   // fills the table
    run_phase(16'd0, 16'd0, 100, 50, 1'b0);        // zero slice and instant aging
    run_phase(16'd31, 16'hffff, 150, 30, 1'b0);    // mostly draining
    run_phase(16'd15, 16'd100, 200, 55, 1'b1);     // back to back words
    run_phase(16'd20, 16'd1, 220, 60, 1'b0);

    wait_idle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/mlfq_pkg.sv
rtl/mlfq_ctrl.sv
rtl/mlfq_dp.sv
rtl/multilevel_feedback_queue_scheduler_unit.sv
dv/multilevel_feedback_queue_scheduler_unit_test.sv
